### design/binary_to_bcd_digit_sequencer_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the binary to BCD digit sequencer
// Shared concurrent check forms. Each use samples on clock and is disabled
// during reset.
// ----------------------------------------------------------------------------
`ifndef BINARY_TO_BCD_DIGIT_SEQUENCER_ASSERT_SVH
`define BINARY_TO_BCD_DIGIT_SEQUENCER_ASSERT_SVH

// Condition implies consequence in the same cycle
`define BTBCD_ASSERT_SAME(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Condition implies consequence in the next cycle
`define BTBCD_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/btbcd_pkg.sv
// ----------------------------------------------------------------------------
// Binary to BCD digit sequencer package
// Widths, limits, queue sizing and the transaction types shared by the design modules.
// ----------------------------------------------------------------------------
`default_nettype none

package btbcd_pkg;

   // Field widths
   localparam int VALUE_W = 32;
   localparam int CNT_W   = 4;
   localparam int BCD_W   = 4;
   localparam int POS_W   = 3;

   // Digit count limits
   localparam int MAX_DIGITS        = 8;
   localparam int DIGIT_COUNT_RESET = 3;

   // Divide by ten through a reciprocal multiply
   localparam int              DIV10_SHIFT = 35;
   localparam logic [VALUE_W-1:0] DIV10_RECIP = 32'hCCCC_CCCD;

   // Queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // One classified value waiting for the digit engine
   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic [CNT_W-1:0]   count;
   } entry_type;

   // Front to queue
   typedef struct packed {
      logic      push;
      entry_type entry;
   } queue_wr_type;

   // Queue to back
   typedef struct packed {
      logic      not_empty;
      entry_type entry;
   } queue_rd_type;

endpackage

`default_nettype wire

### design/btbcd_if.sv
// ----------------------------------------------------------------------------
// Binary to BCD digit sequencer channel interfaces
// Valid/ready channels for the request values and the digit responses.
// ----------------------------------------------------------------------------
`default_nettype none

interface btbcd_req_if;
   logic                          valid;
   logic                          ready;
   logic [btbcd_pkg::VALUE_W-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

interface btbcd_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [btbcd_pkg::BCD_W-1:0] bcd_digit;
   logic [btbcd_pkg::POS_W-1:0] digit_position;
   logic                        last_digit;

   modport source (output valid, output bcd_digit, output digit_position,
                   output last_digit, input ready);
   modport sink   (input valid, input bcd_digit, input digit_position,
                   input last_digit, output ready);
endinterface

`default_nettype wire

### design/btbcd_front.sv
// ----------------------------------------------------------------------------
// Binary to BCD front end
// Holds the digit count register, accepts request transactions, clamps the
// count and queues values that produce at least one digit.
// ----------------------------------------------------------------------------
`default_nettype none

module btbcd_front (
   input  wire logic                        clock,
   input  wire logic                        reset,
   btbcd_req_if.sink                        req,
   input  wire logic                        csr_write_enable,
   input  wire logic [btbcd_pkg::CNT_W-1:0] csr_write_data,
   input  wire logic                        queue_full,
   output btbcd_pkg::queue_wr_type          wr
);

   logic [btbcd_pkg::CNT_W-1:0] digit_count_ff;
   logic [btbcd_pkg::CNT_W-1:0] digit_count_in;
   logic [btbcd_pkg::CNT_W-1:0] eff_count;

   // Update the digit count register
   always_comb begin
      digit_count_in = digit_count_ff;
      if (csr_write_enable) begin
         digit_count_in = csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         digit_count_ff <= btbcd_pkg::CNT_W'(btbcd_pkg::DIGIT_COUNT_RESET);
      end else begin
         digit_count_ff <= digit_count_in;
      end
   end

   // Clamp the count to the supported number of digits
   always_comb begin
      eff_count = digit_count_ff;
      if (digit_count_ff > btbcd_pkg::CNT_W'(btbcd_pkg::MAX_DIGITS)) begin
         eff_count = btbcd_pkg::CNT_W'(btbcd_pkg::MAX_DIGITS);
      end
   end

   // Accept while the queue has room; drop values with a zero count
   assign req.ready      = !queue_full;
   assign wr.push        = req.valid && !queue_full && (eff_count != '0);
   assign wr.entry.value = req.value;
   assign wr.entry.count = eff_count;

endmodule

`default_nettype wire

### design/btbcd_queue.sv
// ----------------------------------------------------------------------------
// Binary to BCD decoupling queue
// Short FIFO of classified values between the front end and the digit engine.
// ----------------------------------------------------------------------------
`default_nettype none
`include "binary_to_bcd_digit_sequencer_assert.svh"

module btbcd_queue (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire btbcd_pkg::queue_wr_type wr,
   input  wire logic                    pop,
   output btbcd_pkg::queue_rd_type      rd,
   output logic                         full
);

   localparam logic [btbcd_pkg::QUEUE_PTR_W-1:0] PtrLast =
      btbcd_pkg::QUEUE_PTR_W'(btbcd_pkg::QUEUE_DEPTH - 1);
   localparam logic [btbcd_pkg::QUEUE_CNT_W-1:0] CntFull =
      btbcd_pkg::QUEUE_CNT_W'(btbcd_pkg::QUEUE_DEPTH);

   btbcd_pkg::entry_type                entry_ff [btbcd_pkg::QUEUE_DEPTH];
   logic [btbcd_pkg::QUEUE_PTR_W-1:0]   wr_ptr_ff;
   logic [btbcd_pkg::QUEUE_PTR_W-1:0]   wr_ptr_in;
   logic [btbcd_pkg::QUEUE_PTR_W-1:0]   rd_ptr_ff;
   logic [btbcd_pkg::QUEUE_PTR_W-1:0]   rd_ptr_in;
   logic [btbcd_pkg::QUEUE_CNT_W-1:0]   count_ff;
   logic [btbcd_pkg::QUEUE_CNT_W-1:0]   count_in;
   logic                                do_pop;

   assign full         = (count_ff == CntFull);
   assign rd.not_empty = (count_ff != '0);
   assign rd.entry     = entry_ff[rd_ptr_ff];
   assign do_pop       = pop && rd.not_empty;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (wr.push) begin
         wr_ptr_in = (wr_ptr_ff == PtrLast) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrLast) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({wr.push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed entry
   always_ff @(posedge clock) begin
      if (wr.push) begin
         entry_ff[wr_ptr_ff] <= wr.entry;
      end
   end

   `BTBCD_ASSERT_SAME(a_queue_no_overflow, wr.push, !full, "push into full queue")
   `BTBCD_ASSERT_SAME(a_queue_count_range, 1'b1, count_ff <= CntFull,
                      "queue count out of range")
   `BTBCD_ASSERT_NEXT(a_queue_push_visible, wr.push, rd.not_empty,
                      "pushed entry not visible")

endmodule

`default_nettype wire

### design/btbcd_back.sv
// ----------------------------------------------------------------------------
// Binary to BCD digit engine
// Takes queued values and emits one digit per cycle while the response side accepts,
// least significant first, through a registered response stage.
// ----------------------------------------------------------------------------
`default_nettype none
`include "binary_to_bcd_digit_sequencer_assert.svh"

module btbcd_back (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire btbcd_pkg::queue_rd_type rd,
   output logic                         pop,
   btbcd_rsp_if.source                  rsp
);

   logic                            busy_ff;
   logic                            busy_in;
   logic [btbcd_pkg::VALUE_W-1:0]   rest_ff;
   logic [btbcd_pkg::VALUE_W-1:0]   rest_in;
   logic [btbcd_pkg::CNT_W-1:0]     pos_ff;
   logic [btbcd_pkg::CNT_W-1:0]     pos_in;
   logic                            rsp_valid_ff;
   logic                            rsp_valid_in;
   logic [btbcd_pkg::BCD_W-1:0]     bcd_digit_ff;
   logic [btbcd_pkg::POS_W-1:0]     digit_position_ff;
   logic                            last_digit_ff;

   logic [2*btbcd_pkg::VALUE_W-1:0] product;
   logic [btbcd_pkg::VALUE_W-1:0]   quot;
   logic [btbcd_pkg::VALUE_W-1:0]   quot_x10;
   logic [btbcd_pkg::BCD_W-1:0]     rem;
   logic                            out_adv;
   logic                            fire;
   logic                            finishing;

   // Divide the remaining value by ten
   assign product  = (2*btbcd_pkg::VALUE_W)'(rest_ff) *
                     (2*btbcd_pkg::VALUE_W)'(btbcd_pkg::DIV10_RECIP);
   assign quot     = btbcd_pkg::VALUE_W'(product >> btbcd_pkg::DIV10_SHIFT);
   assign quot_x10 = (quot << 3) + (quot << 1);
   assign rem      = btbcd_pkg::BCD_W'(rest_ff - quot_x10);

   // Step when the response stage is free or drains this cycle
   assign out_adv   = !rsp_valid_ff || rsp.ready;
   assign fire      = busy_ff && out_adv;
   assign finishing = fire && (pos_ff == '0);
   assign pop       = rd.not_empty && (!busy_ff || finishing);

   // Load a new value or advance the current one
   always_comb begin
      busy_in = busy_ff;
      rest_in = rest_ff;
      pos_in  = pos_ff;
      if (pop) begin
         busy_in = 1'b1;
         rest_in = rd.entry.value;
         pos_in  = rd.entry.count - 1'b1;
      end else if (fire) begin
         busy_in = !finishing;
         rest_in = quot;
         pos_in  = pos_ff - 1'b1;
      end
   end

   // Hold or refill the response stage
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rest_ff <= rest_in;
      pos_ff  <= pos_in;
      if (fire) begin
         bcd_digit_ff      <= rem;
         digit_position_ff <= pos_ff[btbcd_pkg::POS_W-1:0];
         last_digit_ff     <= (pos_ff == '0);
      end
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.bcd_digit      = bcd_digit_ff;
   assign rsp.digit_position = digit_position_ff;
   assign rsp.last_digit     = last_digit_ff;

   `BTBCD_ASSERT_NEXT(a_back_keep_busy, fire && (pos_ff != '0), busy_ff, "engine stopped early")
   `BTBCD_ASSERT_SAME(a_back_last_pos, rsp_valid_ff && last_digit_ff, digit_position_ff == '0,
                      "last digit not at position zero")
   `BTBCD_ASSERT_SAME(a_back_digit_range, rsp_valid_ff, bcd_digit_ff <= 4'd9, "digit above nine")
   `BTBCD_ASSERT_SAME(a_back_pos_range, busy_ff,
                      pos_ff < btbcd_pkg::CNT_W'(btbcd_pkg::MAX_DIGITS),
                      "position beyond digit limit")

endmodule

`default_nettype wire

### design/binary_to_bcd_digit_sequencer.sv
// ----------------------------------------------------------------------------
// Binary to BCD digit sequencer
// Splits each 32-bit value into digit_count decimal digits (at most 8) and emits
// them least significant first with digit position and last flag.
//
//   Channel  Direction  Handshake      Payload
//   req      in         valid/ready    value[31:0]
//   rsp      out        valid/ready    bcd_digit[3:0], digit_position[2:0],
//                                      last_digit
//   csr      in         write enable   digit_count[3:0]
//
// Each value occupies the digit engine for one divide by ten per digit (1 to 8
// digits, one divide per cycle while rsp is ready); values queue behind it, so
// back-to-back values stream one digit per cycle while rsp is ready. A digit
// count of zero yields no responses. Reset is synchronous and clears the queue,
// engine and response stage; the digit count returns to 3. A stalled rsp stalls
// the engine, then the queue, then req.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_to_bcd_digit_sequencer (
   input  wire logic                        clock,
   input  wire logic                        reset,
   btbcd_req_if.sink                        req,
   btbcd_rsp_if.source                      rsp,
   input  wire logic                        csr_write_enable,
   input  wire logic [btbcd_pkg::CNT_W-1:0] csr_write_data
);

   btbcd_pkg::queue_wr_type wr;
   btbcd_pkg::queue_rd_type rd;
   logic                    queue_full;
   logic                    pop;

   btbcd_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req              (req),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .queue_full       (queue_full),
      .wr               (wr)
   );

   btbcd_queue u_queue (
      .clock (clock),
      .reset (reset),
      .wr    (wr),
      .pop   (pop),
      .rd    (rd),
      .full  (queue_full)
   );

   btbcd_back u_back (
      .clock (clock),
      .reset (reset),
      .rd    (rd),
      .pop   (pop),
      .rsp   (rsp)
   );

endmodule

`default_nettype wire

### dv/tb.sv
// ----------------------------------------------------------------------------
// Binary to BCD digit sequencer testbench
// Feeds 32-bit values through the request channel under several digit counts
// (reset value, 1 to 8, zero and counts above the maximum). Each accepted
// value is split into its expected digits and checked field by field against
// the response stream. Both channels idle at random, the response side holds
// off for a long stretch once, and the last phase runs without idling.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

   import btbcd_pkg::*;

   localparam int RESET_CYCLES = 12;
   localparam int DRAIN_CYCLES = 24;
   localparam int LONG_STALL   = 80;
   localparam int CYCLE_LIMIT  = 300000;
   localparam int PHASE_ITEMS  = 45;
   localparam int ZERO_ITEMS   = 15;
   localparam int NUM_PHASES   = 11;

   typedef struct {
      logic [BCD_W-1:0] bcd_digit;
      logic [POS_W-1:0] digit_position;
      logic             last_digit;
   } digit_result_type;

   logic clock;
   logic reset;
   logic csr_write_enable;
   logic [CNT_W-1:0] csr_write_data;

   btbcd_req_if req_ch ();
   btbcd_rsp_if rsp_ch ();

   binary_to_bcd_digit_sequencer uut (
      .clock            (clock),
      .reset            (reset),
      .req              (req_ch),
      .rsp              (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   logic [VALUE_W-1:0] pending_values[$];
   digit_result_type   digit_expect[$];
   logic [CNT_W-1:0]   digits_setting;
   bit                 calm;
   bit                 rsp_stall_request;
   int                 req_gap;
   int                 rsp_gap;
   int                 rsp_stall_left;
   int                 mismatch_count;
   int                 cycle_count;

   // Generate the clock
   initial clock = 1'b0;
   always #6 clock = ~clock;

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("simulation failed");
         $finish;
      end
   end

   task automatic report_mismatch(input string msg);
      $display("mismatch: %s", msg);
      mismatch_count++;
   endtask

   // Split a value into the digits the block should emit, least significant first
   task automatic expect_digits(input logic [VALUE_W-1:0] value);
      int unsigned      n;
      int unsigned      k;
      logic [VALUE_W-1:0] rest;
      digit_result_type r;
      n = digits_setting;
      if (n > MAX_DIGITS)
         n = MAX_DIGITS;
      rest = value;
      for (k = 0; k < n; k++) begin
         r.bcd_digit      = BCD_W'(rest % 10);
         r.digit_position = POS_W'(n - 1 - k);
         r.last_digit     = (n - 1 - k) == 0;
         rest             = rest / 10;
         digit_expect.push_back(r);
      end
   endtask

   // Compare one response transaction with the oldest expected digit
   task automatic check_digit();
      digit_result_type r;
      if (digit_expect.size() == 0) begin
         report_mismatch($sformatf("unexpected digit %0d pos %0d last %0b",
            rsp_ch.bcd_digit, rsp_ch.digit_position, rsp_ch.last_digit));
      end else begin
         r = digit_expect.pop_front();
         if (rsp_ch.bcd_digit !== r.bcd_digit)
            report_mismatch($sformatf("bcd_digit %0h, want %0h",
               rsp_ch.bcd_digit, r.bcd_digit));
         if (rsp_ch.digit_position !== r.digit_position)
            report_mismatch($sformatf("digit_position %0d, want %0d",
               rsp_ch.digit_position, r.digit_position));
         if (rsp_ch.last_digit !== r.last_digit)
            report_mismatch($sformatf("last_digit %0b, want %0b",
               rsp_ch.last_digit, r.last_digit));
      end
   endtask

   // Driver: predict on each accepted transaction, then offer the next value
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         req_gap = 0;
      end else begin
         if (req_ch.valid && req_ch.ready)
            expect_digits(req_ch.value);
         if (!req_ch.valid || req_ch.ready) begin
            if (req_gap > 0) begin
               req_gap--;
               req_ch.valid <= 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
               req_gap = $urandom_range(1, 7) - 1;
               req_ch.valid <= 1'b0;
            end else if (pending_values.size() != 0) begin
               req_ch.valid <= 1'b1;
               req_ch.value <= pending_values.pop_front();
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: check accepted digits and pace the ready line
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         rsp_gap = 0;
         rsp_stall_left = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready)
            check_digit();
         if (rsp_stall_request) begin
            rsp_stall_request = 1'b0;
            rsp_stall_left = LONG_STALL;
         end
         if (rsp_stall_left > 0) begin
            rsp_stall_left--;
            rsp_ch.ready <= 1'b0;
         end else if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_ch.ready <= 1'b0;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            rsp_gap = $urandom_range(1, 7) - 1;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // Write the digit count register while the block is idle
   task automatic program_digit_count(input logic [CNT_W-1:0] n);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= n;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      digits_setting = n;
   endtask

   // Hold the sender until every value is in and every digit is out
   task automatic settle();
      while (pending_values.size() != 0 || req_ch.valid)
         @(posedge clock);
      while (digit_expect.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Mix of full-range values, small values and decade boundaries
   function automatic logic [VALUE_W-1:0] pick_value();
      logic [VALUE_W-1:0] p;
      int                 k;
      p = 1;
      case ($urandom_range(0, 5))
         0, 1: return $urandom;
         2: return $urandom_range(0, 99999);
         3: begin
            k = $urandom_range(0, 9);
            repeat (k) p = p * 10;
            return p - $urandom_range(0, 1);
         end
         4: return 32'hFFFF_FFFF - $urandom_range(0, 1000);
         default: return $urandom_range(0, 9);
      endcase
   endfunction

   logic [CNT_W-1:0] phase_counts [NUM_PHASES] =
      '{4'd4, 4'd2, 4'd8, 4'd0, 4'd6, 4'd12, 4'd1, 4'd5, 4'd3, 4'd7, 4'd8};

   initial begin
      int items;
      reset             = 1'b1;
      csr_write_enable  = 1'b0;
      csr_write_data    = '0;
      req_ch.valid      = 1'b0;
      req_ch.value      = '0;
      rsp_ch.ready      = 1'b0;
      digits_setting    = CNT_W'(DIGIT_COUNT_RESET);
      calm              = 1'b0;
      rsp_stall_request = 1'b0;
      mismatch_count    = 0;
      cycle_count       = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Reset digit count
      pending_values = '{32'd0, 32'hFFFF_FFFF, 32'd999, 32'd1000, 32'd123, 32'd7};
      settle();

      // Full width
      program_digit_count(4'd8);
      pending_values = '{32'd0, 32'hFFFF_FFFF, 32'd99999999, 32'd100000000,
                         32'd12345678, 32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA};
      settle();

      // Single digit
      program_digit_count(4'd1);
      pending_values = '{32'd9, 32'd10, 32'd5};
      settle();

      // Zero digit count: values are taken but nothing comes out
      program_digit_count(4'd0);
      pending_values = '{32'd12345, 32'hFFFF_FFFF};
      settle();

      // Counts above the maximum clamp to eight digits
      program_digit_count(4'd15);
      pending_values = '{32'd1234567890, 32'd0};
      settle();
      program_digit_count(4'd9);
      pending_values = '{32'd987654321, 32'hFFFF_FFFF};
      settle();

      // Random values under a series of digit counts
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         if (ph == NUM_PHASES - 1)
            calm = 1'b1;
         program_digit_count(phase_counts[ph]);
         items = (phase_counts[ph] == 0) ? ZERO_ITEMS : PHASE_ITEMS;
         repeat (items) pending_values.push_back(pick_value());
         // Hold off the response side while values keep coming
         if (ph == 2)
            rsp_stall_request = 1'b1;
         settle();
      end

      if (mismatch_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

`default_nettype wire
